// ===== hdl/gf256_pkg.sv =====
// Shared types, constants and the field multiply for the GF(2^8) unit.
package gf256_pkg;

  localparam logic [8:0]  RESET_POLY = 9'h11B;
  localparam logic [31:0] INV_EXP    = 32'd254;

  localparam logic [1:0] FUNC_ADD = 2'd0;
  localparam logic [1:0] FUNC_MUL = 2'd1;
  localparam logic [1:0] FUNC_POW = 2'd2;
  localparam logic [1:0] FUNC_INV = 2'd3;

  typedef enum logic [2:0] {
    DP_NOP,
    DP_LOAD,
    DP_MULACC,
    DP_SQUARE,
    DP_RES_ADD,
    DP_RES_MUL,
    DP_RES_ACC
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic exp_zero;
    logic exp_lsb;
  } dp_sts_t;

  // carry-less product, then cancel leading terms from x^14 down to x^8
  function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b,
                                        input logic [7:0] poly_lo);
    logic [14:0] prod;
    logic [8:0]  poly;
    prod = '0;
    poly = {1'b1, poly_lo};
    for (int i = 0; i < 8; i++) begin
      if (b[i]) prod = prod ^ ({7'd0, a} << i);
    end
    for (int i = 14; i >= 8; i--) begin
      if (prod[i]) prod = prod ^ ({6'd0, poly} << (i - 8));
    end
    return prod[7:0];
  endfunction

endpackage

// ===== hdl/gf256_req_if.sv =====
// Request channel: operation and operands.
interface gf256_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [7:0]  operand_a;
  logic [7:0]  operand_b;
  logic [31:0] exponent;

  modport source (output valid, func, operand_a, operand_b, exponent, input ready);
  modport sink (input valid, func, operand_a, operand_b, exponent, output ready);
endinterface

// ===== hdl/gf256_rsp_if.sv =====
// Result channel.
interface gf256_rsp_if;
  logic       valid;
  logic       ready;
  logic [7:0] result;

  modport source (output valid, result, input ready);
  modport sink (input valid, result, output ready);
endinterface

// ===== hdl/gf256_cfg_if.sv =====
// Configuration write channel for the reduction polynomial.
interface gf256_cfg_if;
  logic       valid;
  logic       ready;
  logic [8:0] reduction_poly;

  modport source (output valid, reduction_poly, input ready);
  modport sink (input valid, reduction_poly, output ready);
endinterface

// ===== hdl/gf256_dp.sv =====
// Datapath: operand, accumulator and exponent registers around one field multiplier.
module gf256_dp (
  input  logic                clk,
  input  logic                rst,
  input  gf256_pkg::dp_cmd_t  cmd,
  output gf256_pkg::dp_sts_t  sts,
  input  logic [1:0]          req_func,
  input  logic [7:0]          req_operand_a,
  input  logic [7:0]          req_operand_b,
  input  logic [31:0]         req_exponent,
  input  logic                cfg_we,
  input  logic [8:0]          cfg_poly,
  output logic [7:0]          result
);
  import gf256_pkg::*;

  logic [7:0]  poly;
  logic [7:0]  acc;
  logic [7:0]  sq;
  logic [7:0]  opb;
  logic [31:0] expo;
  logic [7:0]  mul_x;
  logic [7:0]  mul_y;
  logic [7:0]  mul_p;

  // x^8 is implied, only the low terms are kept
  always_ff @(posedge clk) begin
    if (rst) begin
      poly <= RESET_POLY[7:0];
    end else if (cfg_we) begin
      poly <= cfg_poly[7:0];
    end
  end

  always_comb begin
    mul_x = (cmd.op == DP_MULACC) ? acc : sq;
    mul_y = (cmd.op == DP_RES_MUL) ? opb : sq;
    mul_p = gf_mul(mul_x, mul_y, poly);
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      DP_LOAD: begin
        acc  <= 8'd1;
        sq   <= req_operand_a;
        opb  <= req_operand_b;
        expo <= (req_func == FUNC_INV) ? INV_EXP : req_exponent;
      end
      DP_MULACC: begin
        acc <= mul_p;
      end
      DP_SQUARE: begin
        sq   <= mul_p;
        expo <= {1'b0, expo[31:1]};
      end
      DP_RES_ADD: begin
        result <= sq ^ opb;
      end
      DP_RES_MUL: begin
        result <= mul_p;
      end
      DP_RES_ACC: begin
        result <= acc;
      end
      default: begin
      end
    endcase
  end

  assign sts.exp_zero = (expo == 32'd0);
  assign sts.exp_lsb  = expo[0];

endmodule

// ===== hdl/gf256_ctrl.sv =====
// Controller: sequences square-and-multiply and owns the request and result handshakes.
module gf256_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  input  logic [1:0]          req_func,
  output logic                req_ready,
  output logic                rsp_valid,
  input  logic                rsp_ready,
  output gf256_pkg::dp_cmd_t  cmd,
  input  gf256_pkg::dp_sts_t  sts
);
  import gf256_pkg::*;

  typedef enum logic [1:0] {ST_IDLE, ST_MUL, ST_SQR, ST_FIN} state_t;

  state_t state, state_next;
  dp_op_t res_op, res_op_next;
  logic   rsp_valid_next;
  logic   out_free;

  assign req_ready = (state == ST_IDLE) && !rst;
  assign out_free  = !rsp_valid || rsp_ready;

  always_comb begin
    state_next     = state;
    res_op_next    = res_op;
    rsp_valid_next = rsp_valid && !rsp_ready;
    cmd.op         = DP_NOP;
    case (state)
      ST_IDLE: begin
        if (req_valid) begin
          cmd.op = DP_LOAD;
          if (req_func == FUNC_ADD) begin
            res_op_next = DP_RES_ADD;
            state_next  = ST_FIN;
          end else if (req_func == FUNC_MUL) begin
            res_op_next = DP_RES_MUL;
            state_next  = ST_FIN;
          end else begin
            res_op_next = DP_RES_ACC;
            state_next  = ST_MUL;
          end
        end
      end
      ST_MUL: begin
        if (sts.exp_zero) begin
          state_next = ST_FIN;
        end else if (sts.exp_lsb) begin
          cmd.op     = DP_MULACC;
          state_next = ST_SQR;
        end else begin
          // clear bit: square straight away
          cmd.op = DP_SQUARE;
        end
      end
      ST_SQR: begin
        cmd.op     = DP_SQUARE;
        state_next = ST_MUL;
      end
      ST_FIN: begin
        if (out_free) begin
          cmd.op         = res_op;
          rsp_valid_next = 1'b1;
          state_next     = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      res_op    <= DP_RES_ACC;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      res_op    <= res_op_next;
      rsp_valid <= rsp_valid_next;
    end
  end

  a_hold_result: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp_ready) |=> rsp_valid)
    else $error("pending result dropped");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == DP_RES_ADD || cmd.op == DP_RES_MUL || cmd.op == DP_RES_ACC)
      |-> (!rsp_valid || rsp_ready))
    else $error("result register overwritten while pending");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready) |=> !req_ready)
    else $error("request taken while busy");

  a_square_nonzero: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == DP_SQUARE || cmd.op == DP_MULACC) |-> !sts.exp_zero)
    else $error("exponent step with zero exponent");

endmodule

// ===== hdl/gf256_arithmetic_unit_top.sv =====
// Add and multiply go from accept straight to the result step; power squares for each
// exponent bit up to the highest set bit and multiplies once more for each set bit;
// inverse is a power by 254. One shared field multiplier does one product per cycle.
// A new request is taken the cycle after the result is registered; the result register
// lets the next request start while the previous result waits.
// Synchronous reset: idle, no pending result, reduction polynomial 0x11B, nothing taken.
module gf256_arithmetic_unit_top (
  input  logic         clk,
  input  logic         rst,
  gf256_req_if.sink    req,
  gf256_rsp_if.source  rsp,
  gf256_cfg_if.sink    cfg
);
  import gf256_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  assign cfg.ready = !rst;

  gf256_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_func  (req.func),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  gf256_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .req_func      (req.func),
    .req_operand_a (req.operand_a),
    .req_operand_b (req.operand_b),
    .req_exponent  (req.exponent),
    .cfg_we        (cfg.valid),
    .cfg_poly      (cfg.reduction_poly),
    .result        (rsp.result)
  );

endmodule

// ===== tb/gf256_result_checker.sv =====
// Checker for the GF(2^8) unit: follows requests and config writes, predicts and compares results.
module gf256_result_checker (
  input  logic        clk,
  input  logic        rst,
  gf256_req_if        req,
  gf256_rsp_if        rsp,
  gf256_cfg_if        cfg,
  output int unsigned failures,
  output int unsigned outstanding,
  output int unsigned results_checked
);
  timeunit 1ns;
  timeprecision 1ps;

  import gf256_pkg::*;

  typedef struct {
    logic [1:0]  func;
    logic [7:0]  operand_a;
    logic [7:0]  operand_b;
    logic [31:0] exponent;
    logic [7:0]  value;
  } field_result_t;

  field_result_t predicted_bytes[$];
  logic [7:0]    poly_terms;
  int unsigned   fail_cnt;
  int unsigned   check_cnt;

  // shift-and-add product; x^8 always folds back onto the low terms
  function automatic logic [7:0] field_product(input logic [7:0] x, input logic [7:0] y,
                                               input logic [7:0] low_terms);
    logic [7:0] acc;
    logic [7:0] shifted;
    logic [7:0] mult;
    logic       carry;
    acc = '0;
    shifted = x;
    mult = y;
    for (int k = 0; k < 8; k++) begin
      if (mult[0]) acc = acc ^ shifted;
      carry = shifted[7];
      shifted = shifted << 1;
      if (carry) shifted = shifted ^ low_terms;
      mult = mult >> 1;
    end
    return acc;
  endfunction

  function automatic logic [7:0] field_power(input logic [7:0] base, input logic [31:0] e,
                                             input logic [7:0] low_terms);
    logic [7:0] acc;
    logic [7:0] sq;
    acc = 8'h01;
    sq = base;
    for (int k = 0; k < 32; k++) begin
      if (e[k]) acc = field_product(acc, sq, low_terms);
      sq = field_product(sq, sq, low_terms);
    end
    return acc;
  endfunction

  function automatic logic [7:0] predict_byte(input logic [1:0] f, input logic [7:0] a,
                                              input logic [7:0] b, input logic [31:0] e,
                                              input logic [7:0] low_terms);
    case (f)
      FUNC_ADD: return a ^ b;
      FUNC_MUL: return field_product(a, b, low_terms);
      FUNC_POW: return field_power(a, e, low_terms);
      default:  return field_power(a, INV_EXP, low_terms);
    endcase
  endfunction

  always @(posedge clk) begin
    field_result_t item;
    field_result_t head;
    if (rst) begin
      predicted_bytes.delete();
      poly_terms = RESET_POLY[7:0];
      fail_cnt = 0;
      check_cnt = 0;
    end else begin
      if (cfg.valid && cfg.ready) poly_terms = cfg.reduction_poly[7:0];
      if (req.valid && req.ready) begin
        item.func = req.func;
        item.operand_a = req.operand_a;
        item.operand_b = req.operand_b;
        item.exponent = req.exponent;
        item.value = predict_byte(req.func, req.operand_a, req.operand_b, req.exponent,
                                  poly_terms);
        predicted_bytes = {predicted_bytes, item};
      end
      if (rsp.valid && rsp.ready) begin
        if (predicted_bytes.size() == 0) begin
          fail_cnt++;
          $display("%0t: result %02h with no request waiting", $time, rsp.result);
        end else begin
          head = predicted_bytes.pop_front();
          check_cnt++;
          if (rsp.result !== head.value) begin
            fail_cnt++;
            $display("%0t: mismatch func %0d a %02h b %02h e %08h, expected %02h actual %02h",
                     $time, head.func, head.operand_a, head.operand_b, head.exponent,
                     head.value, rsp.result);
          end
        end
      end
    end
    failures <= fail_cnt;
    results_checked <= check_cnt;
    outstanding <= predicted_bytes.size();
  end

endmodule

// ===== tb/tb_top.sv =====
// Testbench top for the GF(2^8) unit: clock, reset, request and config stimulus, verdict.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import gf256_pkg::*;

  localparam int unsigned LONG_STALL_CYCLES = 150;
  localparam int unsigned ITEMS_PER_PHASE   = 205;
  localparam int unsigned NUM_PHASES        = 8;
  localparam int unsigned CYCLE_LIMIT       = 600000;

  logic clk = 1'b0;
  logic rst;

  gf256_req_if req_ch ();
  gf256_rsp_if rsp_ch ();
  gf256_cfg_if cfg_ch ();

  int unsigned failures;
  int unsigned outstanding;
  int unsigned results_checked;
  int unsigned cycle_cnt = 0;
  int unsigned func_cnt [4];
  int unsigned poly_writes = 0;

  bit sender_idling = 1'b0;
  bit sink_idling   = 1'b0;
  bit stall_request = 1'b0;

  always #1 clk = ~clk;

  gf256_arithmetic_unit_top u_dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch),
    .cfg (cfg_ch)
  );

  gf256_result_checker u_checker (
    .clk             (clk),
    .rst             (rst),
    .req             (req_ch),
    .rsp             (rsp_ch),
    .cfg             (cfg_ch),
    .failures        (failures),
    .outstanding     (outstanding),
    .results_checked (results_checked)
  );

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_cnt, outstanding);
      $display("simulation failed");
      $finish;
    end
  end

  // result side: random back-pressure bursts, plus one long hold-off on request
  initial begin
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (stall_request) begin
        rsp_ch.ready <= 1'b0;
        repeat (LONG_STALL_CYCLES) @(posedge clk);
        stall_request = 1'b0;
        rsp_ch.ready <= 1'b1;
      end else if (sink_idling && $urandom_range(0, 3) == 0) begin
        rsp_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk);
        rsp_ch.ready <= 1'b1;
      end else begin
        rsp_ch.ready <= 1'b1;
      end
    end
  end

  task automatic send_request(input logic [1:0] f, input logic [7:0] a, input logic [7:0] b,
                              input logic [31:0] e);
    if (sender_idling && $urandom_range(0, 3) == 0) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    req_ch.valid     <= 1'b1;
    req_ch.func      <= f;
    req_ch.operand_a <= a;
    req_ch.operand_b <= b;
    req_ch.exponent  <= e;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    func_cnt[f]++;
  endtask

  // the count from the checker is registered, hence the first step
  task automatic drain_results();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  task automatic write_poly(input logic [8:0] p);
    cfg_ch.valid          <= 1'b1;
    cfg_ch.reduction_poly <= p;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    poly_writes++;
  endtask

  function automatic logic [7:0] pick_operand();
    case ($urandom_range(0, 15))
      0, 1:    return 8'h00;
      2, 3:    return 8'hFF;
      4:       return 8'h01;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [31:0] pick_exponent();
    case ($urandom_range(0, 7))
      0:       return 32'd0;
      1:       return 32'($urandom_range(1, 15));
      2:       return 32'hFFFF_FFFF;
      3:       return 32'd1 << $urandom_range(0, 31);
      4:       return 32'($urandom_range(0, 1023));
      default: return 32'($urandom());
    endcase
  endfunction

  initial begin
    logic [8:0] poly;
    rst                   <= 1'b1;
    req_ch.valid          <= 1'b0;
    req_ch.func           <= FUNC_ADD;
    req_ch.operand_a      <= '0;
    req_ch.operand_b      <= '0;
    req_ch.exponent       <= '0;
    cfg_ch.valid          <= 1'b0;
    cfg_ch.reduction_poly <= RESET_POLY;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // directed: extremes, every operation, zero exponent, zero inverse, ignored fields
    send_request(FUNC_ADD, 8'h00, 8'h00, 32'hFFFF_FFFF);
    send_request(FUNC_ADD, 8'hFF, 8'hFF, 32'd0);
    send_request(FUNC_ADD, 8'h55, 8'hAA, 32'h1234_5678);
    send_request(FUNC_MUL, 8'h00, 8'hFF, 32'd7);
    send_request(FUNC_MUL, 8'hFF, 8'hFF, 32'd0);
    send_request(FUNC_MUL, 8'h53, 8'hCA, 32'hFFFF_FFFF);
    send_request(FUNC_MUL, 8'h01, 8'h80, 32'd0);
    send_request(FUNC_MUL, 8'h80, 8'h80, 32'd0);
    send_request(FUNC_POW, 8'h00, 8'hFF, 32'd0);
    send_request(FUNC_POW, 8'hFF, 8'h00, 32'd0);
    send_request(FUNC_POW, 8'h00, 8'h00, 32'd5);
    send_request(FUNC_POW, 8'h02, 8'h5A, 32'hFFFF_FFFF);
    send_request(FUNC_POW, 8'h03, 8'h00, 32'h8000_0000);
    send_request(FUNC_POW, 8'h03, 8'hFF, 32'd255);
    send_request(FUNC_INV, 8'h00, 8'hFF, 32'hFFFF_FFFF);
    send_request(FUNC_INV, 8'h01, 8'h00, 32'd0);
    send_request(FUNC_INV, 8'hFF, 8'h12, 32'd3);
    send_request(FUNC_INV, 8'h53, 8'h00, 32'd0);
    drain_results();

    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      case (phase)
        0:       poly = RESET_POLY;
        1:       poly = 9'h100;             // x^8 alone: reducible
        2:       poly = 9'h1FF;
        3:       poly = 9'h01B;             // bit 8 clear, still taken as set
        4:       poly = 9'h11D;
        default: poly = 9'h100 | 9'($urandom_range(0, 255));
      endcase
      write_poly(poly);
      sender_idling = (phase != 4) && (phase != NUM_PHASES - 1);
      sink_idling   = sender_idling;
      if (phase == 2) stall_request = 1'b1;
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        send_request(2'($urandom_range(0, 3)), pick_operand(), pick_operand(),
                     pick_exponent());
        // mid-phase pause with no config write
        if (phase == 5 && n == ITEMS_PER_PHASE / 2) drain_results();
      end
      drain_results();
    end

    repeat (80) @(posedge clk);
    $display("%0d results checked over %0d polynomial writes", results_checked, poly_writes);
    $display("requests: add %0d, multiply %0d, power %0d, inverse %0d",
             func_cnt[FUNC_ADD], func_cnt[FUNC_MUL], func_cnt[FUNC_POW], func_cnt[FUNC_INV]);
    if (failures == 0 && outstanding == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
